[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the stable priority queue
// Request and result transaction types, slot contents, cell command and
// status codes used by the queue cells and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_DEPTH   = 16;
  localparam int SPQ_VALUE_W = 32;
  localparam int SPQ_PRIO_W  = 16;
  localparam int SPQ_COUNT_W = 5;

  typedef enum logic [0:0] {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } spq_req_type_t;

  typedef enum logic [1:0] {
    SPQ_OK        = 2'd0,
    SPQ_POP_EMPTY = 2'd1,
    SPQ_INS_FULL  = 2'd2
  } spq_status_t;

  // request transaction
  typedef struct packed {
    spq_req_type_t           req_type;
    logic [SPQ_VALUE_W-1:0]  entry_value;
    logic [SPQ_PRIO_W-1:0]   entry_priority;
  } spq_req_t;

  // result transaction
  typedef struct packed {
    logic [SPQ_VALUE_W-1:0]  pop_data;
    logic                    pop_valid;
    spq_status_t             status;
    logic [SPQ_COUNT_W-1:0]  entry_count;
    logic                    queue_empty;
  } spq_result_t;

  // contents of one slot
  typedef struct packed {
    logic                    used;
    logic [SPQ_PRIO_W-1:0]   prio;
    logic [SPQ_VALUE_W-1:0]  value;
  } spq_slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic [SPQ_PRIO_W-1:0]   prio;
    logic [SPQ_VALUE_W-1:0]  value;
  } spq_cmd_t;

endpackage

[sv/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry, compares it against an inserted priority and either keeps
// it, takes the new entry, or takes a neighbor's entry to shift the row.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_cmd_t  cmd,
  input  spq_pkg::spq_slot_t left_slot,
  input  logic               left_keep,
  input  spq_pkg::spq_slot_t right_slot,
  output spq_pkg::spq_slot_t slot,
  output logic               keep
);
  import spq_pkg::*;

  spq_slot_t slot_next;

  // entry stays put on insert when it ranks at or above the new one
  assign keep = slot.used && (slot.prio >= cmd.prio);

  // choose the next slot contents
  always_comb begin
    slot_next = slot;
    if (cmd.insert) begin
      if (keep) begin
        slot_next = slot;
      end else if (left_keep) begin
        slot_next.used  = 1'b1;
        slot_next.prio  = cmd.prio;
        slot_next.value = cmd.value;
      end else begin
        slot_next = left_slot;
      end
    end else if (cmd.remove) begin
      slot_next = right_slot;
    end
  end

  // occupancy is reset, payload is not
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.used <= 1'b0;
    end else begin
      slot.used <= slot_next.used;
    end
    slot.prio  <= slot_next.prio;
    slot.value <= slot_next.value;
  end

`ifndef SYNTHESIS
  // a cell that keeps its entry on insert stays occupied
  assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && keep) |=> slot.used)
    else $error("spq_cell: kept entry lost on insert");
  // a cell loading the new entry becomes occupied
  assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && !keep && left_keep) |=> (slot.used && slot.value == $past(cmd.value)))
    else $error("spq_cell: inserted entry not captured");
  // insert and remove are never issued together
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert && cmd.remove))
    else $error("spq_cell: conflicting command");
`endif

endmodule

[sv/stable_priority_queue.sv]
// A request taken on start gives its result on done in the next cycle.
// Throughput: one request per cycle; busy is always low, the chain of slot
// cells updates every entry in the same cycle by neighbor shifts.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset (rst, synchronous) empties the queue; slot payloads are not cleared.
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted priority queue
// A row of compare-and-shift cells kept in descending priority order; equal
// priorities leave in arrival order. Reports count and empty on every result.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  spq_pkg::spq_req_t    req,
  output logic                 done,
  output spq_pkg::spq_result_t result
);
  import spq_pkg::*;

  localparam int CountW = $clog2(QUEUE_DEPTH + 1);

  spq_slot_t              slots [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keeps;
  spq_cmd_t               cmd;
  logic                   accept;
  logic                   is_full;
  logic                   no_entries;
  logic [CountW-1:0]      count;
  logic [CountW-1:0]      count_next;
  spq_result_t            result_next;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign no_entries = !slots[0].used;
  assign is_full    = slots[QUEUE_DEPTH-1].used;

  // broadcast command, gated by full and empty
  always_comb begin
    cmd.insert = accept && (req.req_type == REQ_INSERT) && !is_full;
    cmd.remove = accept && (req.req_type == REQ_POP) && !no_entries;
    cmd.prio   = req.entry_priority;
    cmd.value  = req.entry_value;
  end

  // chain of cells; the head sees an always-kept neighbor, the tail an empty one
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_slot_t left_slot;
    spq_slot_t right_slot;
    logic      left_keep;

    if (i == 0) begin : g_head
      assign left_slot = '{used: 1'b1, prio: '0, value: '0};
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_slot = slots[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_slot = '{used: 1'b0, prio: '0, value: '0};
    end else begin : g_inner
      assign right_slot = slots[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left_slot  (left_slot),
      .left_keep  (left_keep),
      .right_slot (right_slot),
      .slot       (slots[i]),
      .keep       (keeps[i])
    );
  end

  // entry count after this transaction
  always_comb begin
    count_next = count;
    if (cmd.insert) begin
      count_next = count + CountW'(1);
    end else if (cmd.remove) begin
      count_next = count - CountW'(1);
    end
  end

  // result of this transaction
  always_comb begin
    result_next.pop_data    = cmd.remove ? slots[0].value : '0;
    result_next.pop_valid   = cmd.remove;
    result_next.status      = SPQ_OK;
    if (req.req_type == REQ_POP && no_entries) begin
      result_next.status = SPQ_POP_EMPTY;
    end else if (req.req_type == REQ_INSERT && is_full) begin
      result_next.status = SPQ_INS_FULL;
    end
    result_next.entry_count = SPQ_COUNT_W'(count_next);
    result_next.queue_empty = (count_next == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      count <= '0;
    end else begin
      done  <= accept;
      count <= count_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // every accepted transaction gives a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("stable_priority_queue: missing result");
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("stable_priority_queue: spurious result");
  // count agrees with head occupancy
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !slots[0].used)
    else $error("stable_priority_queue: count out of step with slots");
  // a dropped insert only happens with a full queue
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == SPQ_INS_FULL) |-> (count == CountW'(QUEUE_DEPTH)))
    else $error("stable_priority_queue: insert dropped while not full");
  // a popped value always comes with ok status
  assert property (@(posedge clk) disable iff (rst)
    (done && result.pop_valid) |-> (result.status == SPQ_OK))
    else $error("stable_priority_queue: pop data with error status");
`endif

endmodule
